>>> design/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared widths, character codes, register indexes and beat types for the
// text console cursor engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int COL_W  = 8;
	localparam int ROW_W  = 7;
	localparam int COLS_W = 9;
	localparam int ROWS_W = 8;
	localparam int CHAR_W = 8;
	localparam int COLOR_W = 32;

	localparam int COL_SPAN = 2 ** COL_W;
	localparam int MAX_COLS = 256;
	localparam int MAX_ROWS = 128;

	// A single character causes at most this many cell writes.
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	localparam int TAB_WIDTH_DEF = 8;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	localparam int ADDR_W = 3;
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	localparam logic [COLS_W-1:0] COLUMNS_RESET = 9'd80;
	localparam logic [ROWS_W-1:0] ROWS_RESET    = 8'd25;

	typedef struct packed {
		logic [CHAR_W-1:0]  char_code;
		logic [COLOR_W-1:0] fg_color;
		logic [COLOR_W-1:0] bg_color;
	} char_item_t;

	typedef struct packed {
		logic [COL_W-1:0]   cell_col;
		logic [ROW_W-1:0]   cell_row;
		logic [CHAR_W-1:0]  glyph_code;
		logic [COLOR_W-1:0] cell_fg;
		logic [COLOR_W-1:0] cell_bg;
		logic               last;
	} cell_item_t;

endpackage

>>> design/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// An accepted character is registered in the input stage (valid_s1, item_s1);
// its cell beats are then registered in the output register when it is free.
// Throughput: one character per cycle while no tab is in progress and the cell
// output is not stalled; a tab writes one space per beat (up to eight), set by the single cell-write port.
// Reset clears the cursor and valids and loads 80 columns by 25 rows.
// ----------------------------------------------------------------------------
module text_console_cursor_engine
	import tcc_pkg::*;
#(
	parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,

	input  logic              char_valid,
	output logic              char_stall,
	input  char_item_t        char_item,

	output logic              cell_valid,
	input  logic              cell_stall,
	output cell_item_t        cell_item
);

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} cursor_t;

	typedef logic [COL_SPAN-1:0][CNT_W-1:0] spaces_tab_t;

	// Spaces a tab writes from each starting column.
	function automatic spaces_tab_t build_spaces();
		spaces_tab_t t;
		int s;
		for (int i = 0; i < COL_SPAN; i++) begin
			s = TAB_WIDTH - (i % TAB_WIDTH);
			if (s > MAX_RESULTS) s = MAX_RESULTS;
			t[i] = CNT_W'(s);
		end
		return t;
	endfunction

	localparam spaces_tab_t SPACES_TAB = build_spaces();

	function automatic cursor_t wrap_pos(
		input logic [COLS_W-1:0] col,
		input logic [ROWS_W-1:0] row,
		input logic [COLS_W-1:0] ncols,
		input logic [ROWS_W-1:0] nrows
	);
		logic [COLS_W-1:0] c;
		logic [ROWS_W-1:0] r;
		cursor_t p;
		c = col;
		r = row;
		if (c >= ncols) begin
			r = r + ROWS_W'(1);
			c = '0;
		end
		if (r >= nrows) r = '0;
		p.col = c[COL_W-1:0];
		p.row = r[ROW_W-1:0];
		return p;
	endfunction

	logic [COLS_W-1:0] columns_q;
	logic [ROWS_W-1:0] rows_q;
	logic [COLS_W-1:0] eff_cols;
	logic [ROWS_W-1:0] eff_rows;

	cursor_t           cursor_q;
	logic              tab_active_q;
	logic [CNT_W-1:0]  tab_left_q;

	logic              valid_s1;
	char_item_t        item_s1;

	logic              cell_valid_q;
	cell_item_t        cell_item_q;

	logic              is_nl, is_bs, is_tab;
	logic [CNT_W-1:0]  beat_cnt;
	logic              final_beat;
	logic              out_free;
	logic              fire;
	logic              done;
	logic              cfg_write;
	cursor_t           write_pos;
	cursor_t           next_pos;
	cursor_t           bs_pos;
	logic [CHAR_W-1:0] glyph;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_ROWS) ? {{(32 - ROWS_W){1'b0}}, rows_q}
	                                       : {{(32 - COLS_W){1'b0}}, columns_q};

	always_comb begin
		if (columns_q == '0) eff_cols = COLS_W'(1);
		else if (columns_q > COLS_W'(MAX_COLS)) eff_cols = COLS_W'(MAX_COLS);
		else eff_cols = columns_q;
		if (rows_q == '0) eff_rows = ROWS_W'(1);
		else if (rows_q > ROWS_W'(MAX_ROWS)) eff_rows = ROWS_W'(MAX_ROWS);
		else eff_rows = rows_q;
	end

	assign is_nl  = (item_s1.char_code == CH_NEWLINE);
	assign is_bs  = (item_s1.char_code == CH_BACKSPACE);
	assign is_tab = (item_s1.char_code == CH_TAB);

	// The space count of a tab is fixed from the cursor column at its first beat.
	assign beat_cnt   = tab_active_q ? tab_left_q : SPACES_TAB[cursor_q.col];
	assign final_beat = !is_tab || (beat_cnt == CNT_W'(1));
	assign out_free   = !cell_valid_q || !cell_stall;
	assign fire       = valid_s1 && (is_nl || out_free);
	assign done       = fire && final_beat;
	assign char_stall = valid_s1 && !done;

	always_comb begin
		bs_pos = cursor_q;
		if (cursor_q.col == '0) begin
			bs_pos.col = COL_W'(eff_cols - COLS_W'(1));
			if (cursor_q.row == '0) bs_pos.row = ROW_W'(eff_rows - ROWS_W'(1));
			else bs_pos.row = cursor_q.row - ROW_W'(1);
		end else begin
			bs_pos.col = cursor_q.col - COL_W'(1);
		end
	end

	always_comb begin
		write_pos = cursor_q;
		glyph = item_s1.char_code;
		if (is_nl) begin
			next_pos = wrap_pos('0, {1'b0, cursor_q.row} + ROWS_W'(1), eff_cols, eff_rows);
		end else if (is_bs) begin
			write_pos = bs_pos;
			glyph = CH_SPACE;
			next_pos = wrap_pos({1'b0, bs_pos.col}, {1'b0, bs_pos.row}, eff_cols, eff_rows);
		end else begin
			if (is_tab) glyph = CH_SPACE;
			next_pos = wrap_pos({1'b0, cursor_q.col} + COLS_W'(1), {1'b0, cursor_q.row},
			                    eff_cols, eff_rows);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q    <= COLUMNS_RESET;
			rows_q       <= ROWS_RESET;
			cursor_q     <= '0;
			tab_active_q <= 1'b0;
			tab_left_q   <= '0;
			valid_s1     <= 1'b0;
			cell_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				if (paddr[2] == REG_COLUMNS) columns_q <= pwdata[COLS_W-1:0];
				else rows_q <= pwdata[ROWS_W-1:0];
			end

			if (fire) begin
				cursor_q <= next_pos;
				if (is_tab) begin
					tab_active_q <= !final_beat;
					tab_left_q   <= beat_cnt - CNT_W'(1);
				end
			end

			if (char_valid && !char_stall) valid_s1 <= 1'b1;
			else if (done) valid_s1 <= 1'b0;

			if (out_free) cell_valid_q <= fire && !is_nl;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) item_s1 <= char_item;
		if (fire && !is_nl) begin
			cell_item_q.cell_col   <= write_pos.col;
			cell_item_q.cell_row   <= write_pos.row;
			cell_item_q.glyph_code <= glyph;
			cell_item_q.cell_fg    <= item_s1.fg_color;
			cell_item_q.cell_bg    <= item_s1.bg_color;
			cell_item_q.last       <= final_beat;
		end
	end

	assign cell_valid = cell_valid_q;
	assign cell_item  = cell_item_q;

endmodule

>>> design/tcc_checker.sv
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks on the cell beats of the text console cursor engine.
// ----------------------------------------------------------------------------
module tcc_checker
	import tcc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cell_valid,
	input logic       cell_stall,
	input cell_item_t cell_item
);

	// A stalled beat must hold.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && cell_stall |=> cell_valid && $stable(cell_item))
		else $error("cell beat changed while stalled");

	// Only a tab gives several beats, and all of them are spaces.
	a_space: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_item.last |-> cell_item.glyph_code == CH_SPACE)
		else $error("non-final beat is not a space");

	// The rest of a tab follows without a gap once a beat is taken.
	a_cont: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_stall && !cell_item.last |=>
			cell_valid && cell_item.glyph_code == CH_SPACE)
		else $error("tab beats interrupted");

	// All beats of one character carry the same colors.
	a_color: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_stall && !cell_item.last |=>
			cell_item.cell_fg == $past(cell_item.cell_fg) &&
			cell_item.cell_bg == $past(cell_item.cell_bg))
		else $error("colors changed inside a tab");

endmodule

bind text_console_cursor_engine tcc_checker u_tcc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cell_valid (cell_valid),
	.cell_stall (cell_stall),
	.cell_item  (cell_item)
);

>>> dv/tb_text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine
// Self-checking testbench for the text console cursor engine. A driver
// offers character beats from a pending queue, a predictor tracks the cursor
// and works out the cell writes each accepted character causes, and a monitor
// compares every accepted cell beat with the oldest predicted one. Geometry
// registers are rewritten over the APB port between phases, while idle.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_engine
	import tcc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAB_STOP    = TAB_WIDTH_DEF;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 12;
	localparam int CYCLE_LIMIT = 1000000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              char_valid = 1'b0;
	logic              char_stall;
	char_item_t        char_item = '0;
	logic              cell_valid;
	logic              cell_stall = 1'b0;
	cell_item_t        cell_item;

	// Predictor state: geometry registers and the cursor.
	logic [COLS_W-1:0] cfg_columns = COLUMNS_RESET;
	logic [ROWS_W-1:0] cfg_rows = ROWS_RESET;
	int unsigned       cur_col = 0;
	int unsigned       cur_row = 0;

	char_item_t pending_chars[$];
	cell_item_t cells_due[$];

	int  fails = 0;
	int  chars_sent = 0;
	int  cells_seen = 0;
	int  geometry_count = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_asked = 0;
	int  hold_taken = 0;
	int  cycle_count = 0;
	bit  src_quiet = 1'b0;
	bit  snk_quiet = 1'b0;

	text_console_cursor_engine i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cell_item  (cell_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("text_console_cursor_engine regression: fail");
			$finish;
		end
	end

	function automatic int unsigned line_len();
		if (cfg_columns == 0) return 1;
		if (cfg_columns > MAX_COLS) return MAX_COLS;
		return 32'(cfg_columns);
	endfunction

	function automatic int unsigned page_len();
		if (cfg_rows == 0) return 1;
		if (cfg_rows > MAX_ROWS) return MAX_ROWS;
		return 32'(cfg_rows);
	endfunction

	function automatic void wrap_cursor();
		if (cur_col >= line_len()) begin
			cur_row++;
			cur_col = 0;
		end
		if (cur_row >= page_len())
			cur_row = 0;
	endfunction

	function automatic void push_cell(logic [CHAR_W-1:0] glyph, char_item_t c, logic fin);
		cell_item_t beat;
		beat.cell_col   = COL_W'(cur_col);
		beat.cell_row   = ROW_W'(cur_row);
		beat.glyph_code = glyph;
		beat.cell_fg    = c.fg_color;
		beat.cell_bg    = c.bg_color;
		beat.last       = fin;
		cells_due.push_back(beat);
	endfunction

	// Advances the cursor for one character and queues the cell writes it causes.
	function automatic void predict_cells(char_item_t c);
		int unsigned spaces;
		case (c.char_code)
		CH_NEWLINE: begin
			cur_row++;
			cur_col = 0;
			wrap_cursor();
		end
		CH_BACKSPACE: begin
			if (cur_col == 0) begin
				cur_col = line_len() - 1;
				if (cur_row == 0)
					cur_row = page_len() - 1;
				else
					cur_row--;
			end else begin
				cur_col--;
			end
			push_cell(CH_SPACE, c, 1'b1);
			wrap_cursor();
		end
		CH_TAB: begin
			spaces = TAB_STOP - (cur_col % TAB_STOP);
			if (spaces > MAX_RESULTS)
				spaces = MAX_RESULTS;
			for (int unsigned i = 0; i < spaces; i++) begin
				push_cell(CH_SPACE, c, i == spaces - 1);
				cur_col++;
				wrap_cursor();
			end
		end
		default: begin
			push_cell(c.char_code, c, 1'b1);
			cur_col++;
			wrap_cursor();
		end
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return $urandom_range(1, 3);
		if (roll < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
			char_item <= '0;
			gap_left = 0;
		end else if (!char_valid || !char_stall) begin
			if (char_valid) begin
				predict_cells(char_item);
				chars_sent++;
			end
			if (gap_left > 0) begin
				char_valid <= 1'b0;
				gap_left--;
			end else if (pending_chars.size() != 0) begin
				char_item <= pending_chars.pop_front();
				char_valid <= 1'b1;
				gap_left = (src_quiet || $urandom_range(0, 99) < 70) ? 0 : pick_gap();
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		cell_item_t want;
		if (!arst_n) begin
			cell_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (cell_valid && !cell_stall) begin
				if (cells_due.size() == 0) begin
					$error("cell beat with nothing expected: col %0d row %0d glyph 0x%0h",
						cell_item.cell_col, cell_item.cell_row, cell_item.glyph_code);
					fails++;
				end else begin
					want = cells_due.pop_front();
					cells_seen++;
					check_field("cell_col", 32'(want.cell_col), 32'(cell_item.cell_col));
					check_field("cell_row", 32'(want.cell_row), 32'(cell_item.cell_row));
					check_field("glyph_code", 32'(want.glyph_code),
						32'(cell_item.glyph_code));
					check_field("cell_fg", want.cell_fg, cell_item.cell_fg);
					check_field("cell_bg", want.cell_bg, cell_item.cell_bg);
					check_field("last", 32'(want.last), 32'(cell_item.last));
				end
			end
			if (hold_taken != hold_asked) begin
				hold_taken = hold_asked;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				cell_stall <= 1'b1;
				stall_left--;
			end else if (!snk_quiet && $urandom_range(0, 99) < 25) begin
				cell_stall <= 1'b1;
				stall_left = pick_gap() - 1;
			end else begin
				cell_stall <= 1'b0;
			end
		end
	end

	// Newlines cause no beats, so an extra settle wait lets the block finish.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_chars.size() != 0 || char_valid || cells_due.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		logic [31:0] mask;
		logic [31:0] got;
		mask = (idx == REG_ROWS) ? 32'hFF : 32'h1FF;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		check_field(idx == REG_ROWS ? "rows readback" : "columns readback",
			value & mask, got & mask);
	endtask

	task automatic set_geometry(input int cols, input int lines);
		wait_idle();
		write_reg(REG_COLUMNS, 32'(cols));
		write_reg(REG_ROWS, 32'(lines));
		cfg_columns = COLS_W'(cols);
		cfg_rows = ROWS_W'(lines);
		geometry_count++;
		@(negedge clk);
	endtask

	task automatic queue_item(input logic [CHAR_W-1:0] code, input logic [31:0] fg,
		input logic [31:0] bg);
		char_item_t c;
		c.char_code = code;
		c.fg_color = fg;
		c.bg_color = bg;
		pending_chars.push_back(c);
	endtask

	task automatic queue_char(input logic [CHAR_W-1:0] code);
		queue_item(code, $urandom, $urandom);
	endtask

	task automatic queue_text(input int n);
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 12)
				queue_char(CH_NEWLINE);
			else if (pick < 22)
				queue_char(CH_BACKSPACE);
			else if (pick < 37)
				queue_char(CH_TAB);
			else
				queue_char(CHAR_W'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset geometry: backspace from home wraps to the bottom row, the
		// next write fills the last cell of the page and wraps to the top.
		queue_char(CH_BACKSPACE);
		queue_item("A", 32'hFFFF_FFFF, 32'h0000_0000);
		queue_item(8'hFF, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_char(8'h00);
		queue_char(CH_TAB);
		queue_char(CH_NEWLINE);
		queue_char(CH_BACKSPACE);
		queue_char(CH_TAB);
		queue_char("a");

		// Narrow screen: a tab runs past the end of the line.
		set_geometry(5, 3);
		queue_char(CH_TAB);
		queue_char(CH_NEWLINE);
		queue_char("x");

		// Counts above range clamp to the largest screen.
		set_geometry(300, 200);
		queue_char(CH_TAB);
		queue_char(CH_TAB);
		queue_char(CH_TAB);
		queue_char("z");

		// Zero counts act as one; the cursor now sits beyond the line.
		set_geometry(0, 0);
		queue_char(CH_BACKSPACE);
		queue_char("q");

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
			0: set_geometry(80, 25);
			1: set_geometry(1, 1);
			2: set_geometry(256, 128);
			3: set_geometry(0, 0);
			4: set_geometry(511, 255);
			5: set_geometry(9, 4);
			6: set_geometry($urandom_range(1, 256), $urandom_range(1, 128));
			default: set_geometry($urandom_range(0, 511), $urandom_range(0, 255));
			endcase
			src_quiet = (ph == 2);
			snk_quiet = (ph == 2);
			queue_text(52);
		end

		// The receiver holds off while the sender keeps offering characters.
		set_geometry(12, 6);
		src_quiet = 1'b1;
		snk_quiet = 1'b0;
		hold_asked++;
		queue_text(48);

		wait_idle();
		$display("Sent %0d characters over %0d screen geometries; %0d cell writes checked.",
			chars_sent, geometry_count, cells_seen);
		if (fails == 0)
			$display("text_console_cursor_engine regression: pass");
		else
			$display("text_console_cursor_engine regression: fail");
		$finish;
	end

endmodule
